@@ design/spims_pkg.sv @@
// Shared types, codes and helpers of the SPI master shifter.
package spims_pkg;

  localparam int unsigned COUNT_WIDTH = 16;
  localparam int unsigned WORD_BITS   = 8;
  localparam int unsigned BIT_CNT_W   = $clog2(WORD_BITS + 1);

  // Command codes carried by an input item.
  localparam logic [2:0] ACT_TICK  = 3'd0;
  localparam logic [2:0] ACT_BEGIN = 3'd1;
  localparam logic [2:0] ACT_XFER  = 3'd2;
  localparam logic [2:0] ACT_END   = 3'd3;
  localparam logic [2:0] ACT_SKIP  = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_LSB    = 2'd1;
  localparam logic [1:0] REG_HALF   = 2'd2;
  localparam logic [1:0] REG_GAP    = 2'd3;

  // Sequencer phases.
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_SHIFT = 2'd1;
  localparam logic [1:0] PH_GAP   = 2'd2;

  typedef struct packed {
    logic [1:0]             spi_mode;
    logic                   lsb_first;
    logic [COUNT_WIDTH-1:0] half_period;
    logic [COUNT_WIDTH-1:0] byte_gap;
  } spims_cfg_t;

  typedef struct packed {
    logic                 sck_level;
    logic                 mosi_level;
    logic                 select_n;
    logic                 busy_res;
    logic                 rx_valid;
    logic [WORD_BITS-1:0] rx_byte;
  } spims_res_t;

  // Shift one sampled MISO bit into the receive register.
  function automatic logic [WORD_BITS-1:0] sample_bit(input logic [WORD_BITS-1:0] cur,
                                                      input logic miso,
                                                      input logic lsb);
    if (lsb) begin
      return {miso, cur[WORD_BITS-1:1]};
    end
    return {cur[WORD_BITS-2:0], miso};
  endfunction

endpackage

@@ design/spims_core.sv @@
// Per-tick SPI sequencer: pin state, shift registers and counters.
module spims_core
  import spims_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [2:0]           action_i,
  input  logic [WORD_BITS-1:0] tx_byte_i,
  input  logic                 miso_level_i,
  input  spims_cfg_t           cfg_i,
  output spims_res_t           res_o
);

  logic [1:0]             phase_q, phase_d;
  logic [WORD_BITS-1:0]   out_q, out_d;
  logic [WORD_BITS-1:0]   in_q, in_d;
  logic [BIT_CNT_W-1:0]   bits_q, bits_d;
  logic [COUNT_WIDTH-1:0] tick_q, tick_d;
  logic                   half2_q, half2_d;
  logic                   clk_q, clk_d;
  logic                   mosi_q, mosi_d;
  logic                   sel_q, sel_d;

  logic [COUNT_WIDTH:0]   tick_inc;
  logic [COUNT_WIDTH-1:0] tick_sat;
  logic [COUNT_WIDTH-1:0] limit;
  logic [BIT_CNT_W-1:0]   bits_inc;
  logic                   cpol, cpha, lsb;
  logic                   rx_done;

  assign cpol     = cfg_i.spi_mode[1];
  assign cpha     = cfg_i.spi_mode[0];
  assign lsb      = cfg_i.lsb_first;
  assign tick_inc = {1'b0, tick_q} + {{COUNT_WIDTH{1'b0}}, 1'b1};
  assign tick_sat = tick_inc[COUNT_WIDTH] ? '1 : tick_inc[COUNT_WIDTH-1:0];
  assign limit    = (cfg_i.half_period == '0) ? {{(COUNT_WIDTH-1){1'b0}}, 1'b1}
                                              : cfg_i.half_period;
  assign bits_inc = bits_q + {{(BIT_CNT_W-1){1'b0}}, 1'b1};

  always_comb begin
    logic [WORD_BITS-1:0] load;
    load    = out_q;
    phase_d = phase_q;
    out_d   = out_q;
    in_d    = in_q;
    bits_d  = bits_q;
    tick_d  = tick_q;
    half2_d = half2_q;
    clk_d   = clk_q;
    mosi_d  = mosi_q;
    sel_d   = sel_q;
    rx_done = 1'b0;
    case (phase_q)
      PH_IDLE: begin
        if (action_i == ACT_BEGIN) begin
          clk_d = cpol;
          sel_d = 1'b0;
        end else if (action_i == ACT_END) begin
          sel_d = 1'b1;
        end else if (action_i == ACT_XFER) begin
          load    = tx_byte_i;
          out_d   = tx_byte_i;
          clk_d   = cpol;
          bits_d  = '0;
          half2_d = 1'b0;
          tick_d  = '0;
          phase_d = PH_SHIFT;
          if (!cpha) begin
            mosi_d = lsb ? load[0] : load[WORD_BITS-1];
            out_d  = lsb ? (load >> 1) : (load << 1);
          end
        end
      end
      PH_SHIFT: begin
        tick_d = tick_sat;
        if (tick_sat >= limit) begin
          tick_d = '0;
          if (!half2_q) begin
            // leading edge
            clk_d   = ~cpol;
            half2_d = 1'b1;
            if (!cpha) begin
              in_d = sample_bit(in_q, miso_level_i, lsb);
            end else begin
              mosi_d = lsb ? out_q[0] : out_q[WORD_BITS-1];
              out_d  = lsb ? (out_q >> 1) : (out_q << 1);
            end
          end else begin
            // trailing edge
            clk_d   = cpol;
            half2_d = 1'b0;
            bits_d  = bits_inc;
            if (cpha) begin
              in_d = sample_bit(in_q, miso_level_i, lsb);
            end
            if (bits_inc >= BIT_CNT_W'(WORD_BITS)) begin
              rx_done = 1'b1;
              bits_d  = '0;
              phase_d = (cfg_i.byte_gap != '0) ? PH_GAP : PH_IDLE;
            end else if (!cpha) begin
              mosi_d = lsb ? out_q[0] : out_q[WORD_BITS-1];
              out_d  = lsb ? (out_q >> 1) : (out_q << 1);
            end
          end
        end
      end
      PH_GAP: begin
        tick_d = tick_sat;
        if (action_i == ACT_SKIP || tick_sat >= cfg_i.byte_gap) begin
          tick_d  = '0;
          phase_d = PH_IDLE;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      out_q   <= '0;
      in_q    <= '0;
      bits_q  <= '0;
      tick_q  <= '0;
      half2_q <= 1'b0;
      clk_q   <= 1'b0;
      mosi_q  <= 1'b0;
      sel_q   <= 1'b1;
    end else if (step_i) begin
      phase_q <= phase_d;
      out_q   <= out_d;
      in_q    <= in_d;
      bits_q  <= bits_d;
      tick_q  <= tick_d;
      half2_q <= half2_d;
      clk_q   <= clk_d;
      mosi_q  <= mosi_d;
      sel_q   <= sel_d;
    end
  end

  // Result reflects the levels after this tick's update.
  assign res_o.sck_level  = clk_d;
  assign res_o.mosi_level = mosi_d;
  assign res_o.select_n   = sel_d;
  assign res_o.busy_res   = (phase_d != PH_IDLE);
  assign res_o.rx_valid   = rx_done;
  assign res_o.rx_byte    = in_d;

`ifndef SYNTHESIS
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> (tick_q == '0 && bits_q == '0 && !half2_q))
    else $error("idle phase with live counters");

  a_bits_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_SHIFT) |-> (bits_q < BIT_CNT_W'(WORD_BITS)))
    else $error("bit count past word length while shifting");

  a_done_cpol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && rx_done) |=> (clk_q == $past(cpol) && phase_q != PH_SHIFT))
    else $error("byte completed away from the idle clock level");
`endif

endmodule

@@ design/spi_master_shifter_top.sv @@
// Top level of the SPI master shifter: config registers, handshake and result register.
//
// Usage:
//   Each input item is one system tick: a command (tick, begin select,
//   transfer byte, end select, skip gap), the byte to send and the MISO level
//   sampled this tick. Every accepted item yields exactly one result item with
//   the SCK, MOSI and select levels after that tick, busy, the received-byte
//   strobe and the receive register.
//   Throughput: one item per clock cycle while results are taken. The tick's step logic sits between
//   the sequencer state and a single result register, so a new item is taken
//   whenever the result register is empty or is being drained.
//   Output: an item's result is registered and shows in the cycle after its acceptance.
//   Stall: while the receiver holds out_ready_i low with a result pending,
//   in_ready_o drops and the sequencer state holds; nothing is lost.
//   Reset: pins idle with SCK low, select high (deselected), the sequencer
//   idle and the registers at mode 0, MSB first, half period 4, no byte gap.
//   Configuration writes are registered; change them only while idle.
module spi_master_shifter_top
  import spims_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration write port
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_index_i,
  input  logic [COUNT_WIDTH-1:0] cfg_wdata_i,
  // tick input channel
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [2:0]             action_i,
  input  logic [WORD_BITS-1:0]   tx_byte_i,
  input  logic                   miso_level_i,
  // result channel
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   sck_level_o,
  output logic                   mosi_level_o,
  output logic                   select_n_o,
  output logic                   busy_res_o,
  output logic                   rx_valid_o,
  output logic [WORD_BITS-1:0]   rx_byte_o
);

  spims_cfg_t cfg_q;
  spims_res_t res_d, res_q;
  logic       out_valid_q;
  logic       accept;

  // Register writes: take the low bits of the data word for narrow registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.spi_mode    <= 2'd0;
      cfg_q.lsb_first   <= 1'b0;
      cfg_q.half_period <= COUNT_WIDTH'(4);
      cfg_q.byte_gap    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MODE: cfg_q.spi_mode    <= cfg_wdata_i[1:0];
        REG_LSB:  cfg_q.lsb_first   <= cfg_wdata_i[0];
        REG_HALF: cfg_q.half_period <= cfg_wdata_i;
        REG_GAP:  cfg_q.byte_gap    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Accept a new tick whenever the result slot is free or drains this cycle.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  spims_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (accept),
    .action_i     (action_i),
    .tx_byte_i    (tx_byte_i),
    .miso_level_i (miso_level_i),
    .cfg_i        (cfg_q),
    .res_o        (res_d)
  );

  // Result valid flag: set on accept, drop once the receiver takes the item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload: load on accept, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sck_level_o  = res_q.sck_level;
  assign mosi_level_o = res_q.mosi_level;
  assign select_n_o   = res_q.select_n;
  assign busy_res_o   = res_q.busy_res;
  assign rx_valid_o   = res_q.rx_valid;
  assign rx_byte_o    = res_q.rx_byte;

endmodule

@@ tb/spi_master_shifter_top_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the SPI master shifter top level.
module spi_master_shifter_top_tb;
  import spims_pkg::*;

  // Actions 5 to 7 carry no command and must behave as a plain tick.
  localparam logic [2:0] ACT_UNKNOWN_LO = 3'd5;
  localparam logic [2:0] ACT_UNKNOWN_HI = 3'd7;

  // Cycles with no handshake on either channel before the run is declared hung.
  localparam int unsigned QUIET_LIMIT = 2000;

  typedef struct packed {
    logic [2:0]           act;
    logic [WORD_BITS-1:0] txb;
    logic                 miso;
  } tick_item_t;

  // DUT stimulus, all known from time zero.
  logic                   clk_i        = 1'b0;
  logic                   rst_ni       = 1'b0;
  logic                   cfg_we_i     = 1'b0;
  logic [1:0]             cfg_index_i  = REG_MODE;
  logic [COUNT_WIDTH-1:0] cfg_wdata_i  = '0;
  logic                   in_valid_i   = 1'b0;
  logic [2:0]             action_i     = ACT_TICK;
  logic [WORD_BITS-1:0]   tx_byte_i    = '0;
  logic                   miso_level_i = 1'b0;
  logic                   out_ready_i  = 1'b0;

  logic                 in_ready_o;
  logic                 out_valid_o;
  logic                 sck_level_o;
  logic                 mosi_level_o;
  logic                 select_n_o;
  logic                 busy_res_o;
  logic                 rx_valid_o;
  logic [WORD_BITS-1:0] rx_byte_o;

  spi_master_shifter_top u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .tx_byte_i    (tx_byte_i),
    .miso_level_i (miso_level_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sck_level_o  (sck_level_o),
    .mosi_level_o (mosi_level_o),
    .select_n_o   (select_n_o),
    .busy_res_o   (busy_res_o),
    .rx_valid_o   (rx_valid_o),
    .rx_byte_o    (rx_byte_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Shared between the phase sequencer, the driver and the monitor.
  tick_item_t  pending_ticks[$];
  spims_res_t  expected_pins[$];
  int unsigned planned_cnt    = 0;
  int unsigned send_idle_pct  = 25;
  int unsigned recv_stall_pct = 25;
  int unsigned mismatch_cnt   = 0;
  int unsigned quiet_cycles   = 0;
  tick_item_t  drv_next;

  // Register copy as the block sees it; starts at the reset values.
  spims_cfg_t cur_cfg = '{spi_mode: 2'd0, lsb_first: 1'b0, half_period: 16'd4, byte_gap: 16'd0};

  // Pin and sequencer state of the shifter model.
  logic [1:0]             seq_phase      = PH_IDLE;
  logic [WORD_BITS-1:0]   tx_sr          = '0;
  logic [WORD_BITS-1:0]   rx_sr          = '0;
  logic [3:0]             bits_done      = '0;
  logic [COUNT_WIDTH-1:0] ticks          = '0;
  logic                   in_second_half = 1'b0;
  logic                   sck_q          = 1'b0;
  logic                   mosi_q         = 1'b0;
  logic                   sel_n_q        = 1'b1;

  // Put the next data bit on MOSI and drop it from the transmit register.
  function automatic void shift_out_bit();
    if (cur_cfg.lsb_first) begin
      mosi_q = tx_sr[0];
      tx_sr  = tx_sr >> 1;
    end else begin
      mosi_q = tx_sr[WORD_BITS-1];
      tx_sr  = tx_sr << 1;
    end
  endfunction

  // Take the MISO level into the receive register, keeping natural bit order.
  function automatic void shift_in_bit(input logic miso);
    if (cur_cfg.lsb_first) begin
      rx_sr = {miso, rx_sr[WORD_BITS-1:1]};
    end else begin
      rx_sr = {rx_sr[WORD_BITS-2:0], miso};
    end
  endfunction

  // Advance the model by one system tick and return the pin levels after it.
  function automatic spims_res_t tick_predict(input logic [2:0] act,
                                              input logic [WORD_BITS-1:0] txb,
                                              input logic miso);
    spims_res_t             res;
    logic [COUNT_WIDTH-1:0] span;
    logic                   strobe;
    strobe = 1'b0;
    // A zero half period runs as one tick per half period.
    span = (cur_cfg.half_period == '0) ? COUNT_WIDTH'(1) : cur_cfg.half_period;
    case (seq_phase)
      PH_IDLE: begin
        if (act == ACT_BEGIN) begin
          sck_q   = cur_cfg.spi_mode[1];
          sel_n_q = 1'b0;
        end else if (act == ACT_END) begin
          sel_n_q = 1'b1;
        end else if (act == ACT_XFER) begin
          // Select is not checked: a transfer runs even when deselected.
          tx_sr          = txb;
          sck_q          = cur_cfg.spi_mode[1];
          bits_done      = '0;
          in_second_half = 1'b0;
          ticks          = '0;
          seq_phase      = PH_SHIFT;
          if (!cur_cfg.spi_mode[0]) shift_out_bit();
        end
      end
      PH_SHIFT: begin
        if (ticks != '1) ticks = ticks + COUNT_WIDTH'(1);
        if (ticks >= span) begin
          ticks = '0;
          if (!in_second_half) begin
            // Leading edge: sample for phase 0, drive for phase 1.
            sck_q = ~cur_cfg.spi_mode[1];
            if (!cur_cfg.spi_mode[0]) shift_in_bit(miso);
            else shift_out_bit();
            in_second_half = 1'b1;
          end else begin
            // Trailing edge: sample for phase 1, then count the bit.
            sck_q = cur_cfg.spi_mode[1];
            if (cur_cfg.spi_mode[0]) shift_in_bit(miso);
            in_second_half = 1'b0;
            bits_done      = bits_done + 4'd1;
            if (bits_done >= 4'(WORD_BITS)) begin
              strobe    = 1'b1;
              bits_done = '0;
              seq_phase = (cur_cfg.byte_gap != '0) ? PH_GAP : PH_IDLE;
            end else if (!cur_cfg.spi_mode[0]) begin
              shift_out_bit();
            end
          end
        end
      end
      default: begin
        // Byte gap: count it out, or cut it short on skip.
        if (ticks != '1) ticks = ticks + COUNT_WIDTH'(1);
        if (act == ACT_SKIP || ticks >= cur_cfg.byte_gap) begin
          ticks     = '0;
          seq_phase = PH_IDLE;
        end
      end
    endcase
    res.sck_level  = sck_q;
    res.mosi_level = mosi_q;
    res.select_n   = sel_n_q;
    res.busy_res   = (seq_phase != PH_IDLE);
    res.rx_valid   = strobe;
    res.rx_byte    = rx_sr;
    return res;
  endfunction

  function automatic void queue_tick(input logic [2:0] act,
                                     input logic [WORD_BITS-1:0] txb,
                                     input logic miso);
    tick_item_t it;
    it.act  = act;
    it.txb  = txb;
    it.miso = miso;
    pending_ticks.push_back(it);
    planned_cnt++;
  endfunction

  function automatic void queue_rand(input logic [2:0] act);
    queue_tick(act, WORD_BITS'($urandom_range(255)), 1'($urandom_range(1)));
  endfunction

  // Mostly plain ticks while busy, with ignored commands mixed in. Keep skip out
  // of the gap filler so that the gap length stays as planned.
  function automatic logic [2:0] busy_action(input bit in_gap);
    logic [2:0] a;
    if ($urandom_range(7) != 0) return ACT_TICK;
    a = 3'($urandom_range(7));
    if (in_gap && a == ACT_SKIP) a = ACT_TICK;
    return a;
  endfunction

  // Queue well-formed frames (select, bytes with their full tick count, gap,
  // deselect) with random content, plus some loose commands as noise.
  task automatic plan_random_ticks(input int unsigned count, input bit with_xfer);
    int unsigned start_cnt;
    int unsigned span;
    int unsigned gap;
    int unsigned skip_at;
    logic [2:0]  a;
    start_cnt = planned_cnt;
    span = (cur_cfg.half_period == '0) ? 1 : 32'(cur_cfg.half_period);
    gap  = 32'(cur_cfg.byte_gap);
    while (planned_cnt - start_cnt < count) begin
      if (!with_xfer || $urandom_range(9) == 0) begin
        a = 3'($urandom_range(7));
        if (!with_xfer && a == ACT_XFER) a = ACT_TICK;
        queue_rand(a);
      end else begin
        if ($urandom_range(3) != 0) queue_rand(ACT_BEGIN);
        repeat ($urandom_range(1, 3)) begin
          queue_rand(ACT_XFER);
          repeat (2 * WORD_BITS * span) queue_rand(busy_action(1'b0));
          if (gap != 0) begin
            if (gap > 64 || $urandom_range(2) == 0) begin
              skip_at = $urandom_range(0, (gap > 21) ? 20 : gap - 1);
              repeat (skip_at) queue_rand(busy_action(1'b1));
              queue_rand(ACT_SKIP);
            end else begin
              repeat (gap) queue_rand(busy_action(1'b1));
            end
          end
          repeat ($urandom_range(2)) queue_rand(ACT_TICK);
        end
        if ($urandom_range(3) != 0) queue_rand(ACT_END);
      end
    end
  endtask

  // Hold until every queued item is sent and every result has come back.
  task automatic wait_drained();
    while (pending_ticks.size() != 0 || in_valid_i || expected_pins.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (2) @(posedge clk_i);
  endtask

  // Write all four registers, one per cycle, then mirror them in the model.
  // Junk in the unused upper bits of the narrow registers must be dropped.
  task automatic load_settings(input logic [1:0] mode, input logic lsb,
                               input logic [COUNT_WIDTH-1:0] half,
                               input logic [COUNT_WIDTH-1:0] gap);
    logic [1:0]             idx [4];
    logic [COUNT_WIDTH-1:0] val [4];
    int                     i;
    idx[0] = REG_MODE;
    idx[1] = REG_LSB;
    idx[2] = REG_HALF;
    idx[3] = REG_GAP;
    val[0] = COUNT_WIDTH'(($urandom << 2) | mode);
    val[1] = COUNT_WIDTH'(($urandom << 1) | lsb);
    val[2] = half;
    val[3] = gap;
    for (i = 0; i < 4; i++) begin
      @(posedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_wdata_i <= val[i];
    end
    @(posedge clk_i);
    cfg_we_i              <= 1'b0;
    cur_cfg.spi_mode      = mode;
    cur_cfg.lsb_first     = lsb;
    cur_cfg.half_period   = half;
    cur_cfg.byte_gap      = gap;
  endtask

  function automatic int unsigned field_bad(input string name,
                                            input logic [WORD_BITS-1:0] want,
                                            input logic [WORD_BITS-1:0] got);
    if (got === want) return 0;
    $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
    return 1;
  endfunction

  // Driver: predict each accepted tick, then offer the next pending one or idle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      seq_phase      = PH_IDLE;
      tx_sr          = '0;
      rx_sr          = '0;
      bits_done      = '0;
      ticks          = '0;
      in_second_half = 1'b0;
      sck_q          = 1'b0;
      mosi_q         = 1'b0;
      sel_n_q        = 1'b1;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_pins.push_back(tick_predict(action_i, tx_byte_i, miso_level_i));
      end
      // The payload may change only once the current item is gone.
      if (!in_valid_i || in_ready_o) begin
        if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_next = pending_ticks.pop_front();
          in_valid_i   <= 1'b1;
          action_i     <= drv_next.act;
          tx_byte_i    <= drv_next.txb;
          miso_level_i <= drv_next.miso;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result with the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin : check_results
    spims_res_t  want;
    int unsigned bad;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_pins.size() == 0) begin
          $error("result arrived with no tick waiting for it");
          mismatch_cnt++;
        end else begin
          want = expected_pins.pop_front();
          bad  = field_bad("sck_level", WORD_BITS'(want.sck_level),
                           WORD_BITS'(sck_level_o))
               + field_bad("mosi_level", WORD_BITS'(want.mosi_level),
                           WORD_BITS'(mosi_level_o))
               + field_bad("select_n", WORD_BITS'(want.select_n),
                           WORD_BITS'(select_n_o))
               + field_bad("busy_res", WORD_BITS'(want.busy_res),
                           WORD_BITS'(busy_res_o))
               + field_bad("rx_valid", WORD_BITS'(want.rx_valid),
                           WORD_BITS'(rx_valid_o))
               + field_bad("rx_byte", want.rx_byte, rx_byte_o);
          mismatch_cnt += bad;
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Phase sequencer: reset, directed ticks, then random phases over several
  // register settings. Registers change only with the block drained.
  // Frames run past each target count, so the targets sit below the item budget.
  initial begin : run_phases
    logic [2:0] a;
    int         i;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: zero half period (runs as one), short gap.
    load_settings(2'd0, 1'b0, 16'd0, 16'd3);
    queue_tick(ACT_TICK, 8'hFF, 1'b1);
    queue_tick(ACT_SKIP, 8'h00, 1'b0);          // skip with no gap running
    queue_tick(ACT_UNKNOWN_LO, 8'hFF, 1'b1);
    queue_tick(ACT_UNKNOWN_HI, 8'h00, 1'b0);
    queue_tick(ACT_END, 8'h5A, 1'b0);           // deselect while already deselected
    queue_tick(ACT_BEGIN, 8'h00, 1'b1);
    queue_tick(ACT_XFER, 8'hFF, 1'b0);
    for (i = 0; i < 2 * WORD_BITS; i++) begin
      // Commands in the middle of a byte must all be ignored.
      case (i)
        3:       a = ACT_BEGIN;
        6:       a = ACT_XFER;
        9:       a = ACT_END;
        12:      a = ACT_UNKNOWN_HI;
        default: a = ACT_TICK;
      endcase
      queue_tick(a, WORD_BITS'($urandom_range(255)), i[0] ^ i[1]);
    end
    queue_tick(ACT_TICK, 8'h00, 1'b1);          // first gap tick
    queue_tick(ACT_SKIP, 8'hFF, 1'b0);          // cut the gap short
    queue_tick(ACT_END, 8'h00, 1'b0);
    wait_drained();

    // Reset values.
    load_settings(2'd0, 1'b0, 16'd4, 16'd0);
    plan_random_ticks(80, 1'b1);
    wait_drained();

    load_settings(2'd1, 1'b1, 16'd1, 16'd0);
    plan_random_ticks(130, 1'b1);
    wait_drained();

    // Pause the sender halfway until every result is back, then resume.
    load_settings(2'd2, 1'b0, 16'd2, 16'd5);
    plan_random_ticks(40, 1'b1);
    wait_drained();
    plan_random_ticks(40, 1'b1);
    wait_drained();

    // Largest gap: always cut short by skip.
    load_settings(2'd3, 1'b1, 16'd3, 16'hFFFF);
    plan_random_ticks(80, 1'b1);
    wait_drained();

    // Long stretch with no idling on either side.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    load_settings(2'd3, 1'b0, 16'd1, 16'd1);
    plan_random_ticks(160, 1'b1);
    wait_drained();
    send_idle_pct  = 25;
    recv_stall_pct = 25;

    // Largest half period: no transfers, only select and loose commands, a byte would take too long.
    load_settings(2'd0, 1'b1, 16'hFFFF, 16'd2);
    plan_random_ticks(100, 1'b0);
    wait_drained();

    load_settings(2'd2, 1'b1, 16'd7, 16'd4);
    plan_random_ticks(80, 1'b1);
    wait_drained();

    load_settings(2'd1, 1'b0, 16'd1, 16'd40);
    plan_random_ticks(60, 1'b1);
    wait_drained();

    repeat (4) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/spims_pkg.sv
design/spims_core.sv
design/spi_master_shifter_top.sv
tb/spi_master_shifter_top_tb.sv
